FILE: src/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, constants and the control store for the PID forcing adjuster.
// ----------------------------------------------------------------------------
package pfa_pkg;

	// field widths
	localparam int VSUM_W   = 64;
	localparam int VOL_W    = 32;
	localparam int VEL_W    = 48;
	localparam int GAIN_W   = 32;
	localparam int FORCE_W  = 64;
	localparam int ERR_W    = VEL_W + 1;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int PROD_W   = VSUM_W + GAIN_W;
	localparam int FRAC_W   = 24;
	localparam int SHIFT_W  = PROD_W - FRAC_W;
	localparam int TERM_W   = SHIFT_W + 1;
	localparam int ACC_W    = TERM_W + 2;
	localparam int CNT_W    = 6;
	localparam int IN_W     = VSUM_W + VOL_W;
	localparam int OUT_W    = FORCE_W + VEL_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 64;
	localparam int PC_W     = 4;

	localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
	localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
	localparam logic [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KI_TA   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KD_TA   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FORCING = 3'd4;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_MEAN,
		OP_ERR,
		OP_ESUM,
		OP_MAG,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_TERM,
		OP_ACC,
		OP_SAT,
		OP_FINISH
	} op_t;

	typedef enum logic [2:0] {
		JMP_NEVER,
		JMP_ALWAYS,
		JMP_NO_INPUT,
		JMP_VOL_ZERO,
		JMP_CNT_NZ,
		JMP_TERM_MORE,
		JMP_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	// program addresses
	localparam pc_t PC_WAIT   = 4'd0;
	localparam pc_t PC_DIVI   = 4'd1;
	localparam pc_t PC_DIVS   = 4'd2;
	localparam pc_t PC_MEAN   = 4'd3;
	localparam pc_t PC_ERR    = 4'd4;
	localparam pc_t PC_ESUM   = 4'd5;
	localparam pc_t PC_MAG    = 4'd6;
	localparam pc_t PC_MULLO  = 4'd7;
	localparam pc_t PC_MULHI  = 4'd8;
	localparam pc_t PC_TERM   = 4'd9;
	localparam pc_t PC_ACC    = 4'd10;
	localparam pc_t PC_SAT    = 4'd11;
	localparam pc_t PC_FINISH = 4'd12;
	localparam pc_t PC_RET    = 4'd13;

	// control store: one word per step
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			PC_WAIT:   w = '{OP_ACCEPT,   JMP_NO_INPUT,  PC_WAIT};
			PC_DIVI:   w = '{OP_DIV_INIT, JMP_VOL_ZERO,  PC_FINISH};
			PC_DIVS:   w = '{OP_DIV_STEP, JMP_CNT_NZ,    PC_DIVS};
			PC_MEAN:   w = '{OP_MEAN,     JMP_NEVER,     PC_WAIT};
			PC_ERR:    w = '{OP_ERR,      JMP_NEVER,     PC_WAIT};
			PC_ESUM:   w = '{OP_ESUM,     JMP_NEVER,     PC_WAIT};
			PC_MAG:    w = '{OP_MAG,      JMP_NEVER,     PC_WAIT};
			PC_MULLO:  w = '{OP_MUL_LO,   JMP_NEVER,     PC_WAIT};
			PC_MULHI:  w = '{OP_MUL_HI,   JMP_NEVER,     PC_WAIT};
			PC_TERM:   w = '{OP_TERM,     JMP_NEVER,     PC_WAIT};
			PC_ACC:    w = '{OP_ACC,      JMP_TERM_MORE, PC_MAG};
			PC_SAT:    w = '{OP_SAT,      JMP_NEVER,     PC_WAIT};
			PC_FINISH: w = '{OP_FINISH,   JMP_OUT_BUSY,  PC_FINISH};
			PC_RET:    w = '{OP_NOP,      JMP_ALWAYS,    PC_WAIT};
			default:   w = '{OP_NOP,      JMP_ALWAYS,    PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

FILE: src/pid_forcing_adjust.sv
// A word is accepted only in the wait step and runs to completion before the next
// is taken; a zero-volume word goes from the divide start straight to the finish step.
// The work for each word is set by the radix-2 divider (64 steps) and the 32x32 multiplies,
// two for each of the three gain terms; the finish step waits while the output is held.
// Reset (arst_n low) clears the sequencer, configuration, counters, output valid, error history and forcing at once.
// ----------------------------------------------------------------------------
// pid_forcing_adjust
// Microcoded PID update of a forcing value from a velocity sum and a volume.
// ----------------------------------------------------------------------------
module pid_forcing_adjust (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pfa_pkg::IN_W-1:0]          s_tdata,   // velocity_sum, cells_volume
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pfa_pkg::OUT_W-1:0]         m_tdata,   // forcing_out, mean_velocity
	output logic [0:0]                        m_tuser,   // volume_zero
	input  logic                              cfg_we,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfa_pkg::CFG_W-1:0]         cfg_data
);
	import pfa_pkg::*;

	// sequencer
	pc_t    pc_q;
	pc_t    pc_d;
	ucode_t uw;
	logic   jump;

	// configuration
	logic [VEL_W-1:0]  target_q;
	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] ki_q;
	logic [GAIN_W-1:0] kd_q;

	// controller state
	logic [FORCE_W-1:0] esum_q;
	logic [ERR_W-1:0]   last_err_q;
	logic [FORCE_W-1:0] forcing_q;

	// datapath
	logic [VSUM_W-1:0]  vsum_q;
	logic [VOL_W-1:0]   vol_q;
	logic [VSUM_W-1:0]  div_q;
	logic [VOL_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               zero_q;
	logic [VEL_W-1:0]   mean_q;
	logic [ERR_W-1:0]   err_q;
	logic [DIFF_W-1:0]  diff_q;
	logic [1:0]         term_idx_q;
	logic [VSUM_W-1:0]  mag_q;
	logic               neg_q;
	logic [VSUM_W-1:0]  plo_q;
	logic [VSUM_W-1:0]  phi_q;
	logic [TERM_W-1:0]  term_q;
	logic [ACC_W-1:0]   acc_q;

	// output register
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic               m_tuser_q;

	logic               accept;
	logic               out_free;
	logic               out_load;
	logic [VOL_W:0]     rem_sh;
	logic               div_ge;
	logic [VEL_W-1:0]   mean_d;
	logic [FORCE_W:0]   esum_sum;
	logic [FORCE_W-1:0] esum_d;
	logic [VSUM_W-1:0]  term_x;
	logic [GAIN_W-1:0]  gain_sel;
	logic [PROD_W-1:0]  prod;
	logic [TERM_W-1:0]  term_mag;
	logic [FORCE_W-1:0] forcing_d;

	assign uw       = ucode_rom(pc_q);
	assign s_tready = (uw.op == OP_ACCEPT);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (uw.op == OP_FINISH) && out_free;

	always_comb begin
		case (uw.cond)
			JMP_NEVER:     jump = 1'b0;
			JMP_ALWAYS:    jump = 1'b1;
			JMP_NO_INPUT:  jump = !s_tvalid;
			JMP_VOL_ZERO:  jump = (vol_q == '0);
			JMP_CNT_NZ:    jump = (cnt_q != '0);
			JMP_TERM_MORE: jump = (term_idx_q != 2'd2);
			JMP_OUT_BUSY:  jump = !out_free;
			default:       jump = 1'b0;
		endcase
	end

	always_comb begin
		pc_d = jump ? uw.target : pc_t'(pc_q + pc_t'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	// restoring divide step
	always_comb begin
		rem_sh = {rem_q, div_q[VSUM_W-1]};
		div_ge = (rem_sh >= {1'b0, vol_q});
	end

	// saturate the quotient magnitude and apply the sign
	always_comb begin
		if (vsum_q[VSUM_W-1]) begin
			if (div_q > {{(VSUM_W-VEL_W){1'b0}}, VEL_MIN})
				mean_d = VEL_MIN;
			else
				mean_d = ~div_q[VEL_W-1:0] + VEL_W'(1);
		end else begin
			if (div_q > {{(VSUM_W-VEL_W){1'b0}}, VEL_MAX})
				mean_d = VEL_MAX;
			else
				mean_d = div_q[VEL_W-1:0];
		end
	end

	always_comb begin
		esum_sum = {esum_q[FORCE_W-1], esum_q}
			+ {{(FORCE_W+1-ERR_W){err_q[ERR_W-1]}}, err_q};
		if (esum_sum[FORCE_W] != esum_sum[FORCE_W-1])
			esum_d = esum_sum[FORCE_W] ? FORCE_MIN : FORCE_MAX;
		else
			esum_d = esum_sum[FORCE_W-1:0];
	end

	always_comb begin
		case (term_idx_q)
			2'd0: begin
				term_x   = {{(VSUM_W-ERR_W){err_q[ERR_W-1]}}, err_q};
				gain_sel = kp_q;
			end
			2'd1: begin
				term_x   = esum_q;
				gain_sel = ki_q;
			end
			default: begin
				term_x   = {{(VSUM_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
				gain_sel = kd_q;
			end
		endcase
	end

	always_comb begin
		prod     = {phi_q, {(PROD_W-VSUM_W){1'b0}}} + {{(PROD_W-VSUM_W){1'b0}}, plo_q};
		term_mag = {1'b0, prod[PROD_W-1:FRAC_W]};
	end

	always_comb begin
		if (acc_q[ACC_W-1:FORCE_W-1] == '0 || acc_q[ACC_W-1:FORCE_W-1] == '1)
			forcing_d = acc_q[FORCE_W-1:0];
		else
			forcing_d = acc_q[ACC_W-1] ? FORCE_MIN : FORCE_MAX;
	end

	// configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			kp_q       <= '0;
			ki_q       <= '0;
			kd_q       <= '0;
			esum_q     <= '0;
			last_err_q <= '0;
			forcing_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET:  target_q <= cfg_data[VEL_W-1:0];
				REG_KP:      kp_q     <= cfg_data[GAIN_W-1:0];
				REG_KI_TA:   ki_q     <= cfg_data[GAIN_W-1:0];
				REG_KD_TA:   kd_q     <= cfg_data[GAIN_W-1:0];
				REG_FORCING: begin
					forcing_q  <= cfg_data[FORCE_W-1:0];
					esum_q     <= '0;
					last_err_q <= '0;
				end
				default: ;
			endcase
		end else begin
			if (uw.op == OP_ESUM)
				esum_q <= esum_d;
			if (uw.op == OP_SAT) begin
				forcing_q  <= forcing_d;
				last_err_q <= err_q;
			end
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			term_idx_q <= '0;
		end else begin
			case (uw.op)
				OP_DIV_INIT: cnt_q <= '1;
				OP_DIV_STEP: cnt_q <= cnt_q - CNT_W'(1);
				OP_ESUM:     term_idx_q <= '0;
				OP_ACC:      term_idx_q <= (term_idx_q == 2'd2) ? 2'd0 : term_idx_q + 2'd1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_ACCEPT: begin
				if (accept) begin
					vsum_q <= s_tdata[VSUM_W-1:0];
					vol_q  <= s_tdata[IN_W-1:VSUM_W];
				end
			end
			OP_DIV_INIT: begin
				div_q  <= vsum_q[VSUM_W-1] ? ~vsum_q + VSUM_W'(1) : vsum_q;
				rem_q  <= '0;
				zero_q <= (vol_q == '0);
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? VOL_W'(rem_sh - {1'b0, vol_q}) : rem_sh[VOL_W-1:0];
				div_q <= {div_q[VSUM_W-2:0], div_ge};
			end
			OP_MEAN: mean_q <= mean_d;
			OP_ERR: begin
				err_q <= {target_q[VEL_W-1], target_q} - {mean_q[VEL_W-1], mean_q};
			end
			OP_ESUM: begin
				diff_q <= {err_q[ERR_W-1], err_q} - {last_err_q[ERR_W-1], last_err_q};
				acc_q  <= {{(ACC_W-FORCE_W){forcing_q[FORCE_W-1]}}, forcing_q};
			end
			OP_MAG: begin
				mag_q <= term_x[VSUM_W-1] ? ~term_x + VSUM_W'(1) : term_x;
				neg_q <= term_x[VSUM_W-1];
			end
			OP_MUL_LO: plo_q <= {{(VSUM_W-GAIN_W){1'b0}}, mag_q[GAIN_W-1:0]}
				* {{(VSUM_W-GAIN_W){1'b0}}, gain_sel};
			OP_MUL_HI: phi_q <= {{(VSUM_W-GAIN_W){1'b0}}, mag_q[VSUM_W-1:GAIN_W]}
				* {{(VSUM_W-GAIN_W){1'b0}}, gain_sel};
			OP_TERM: term_q <= neg_q ? ~term_mag + TERM_W'(1) : term_mag;
			OP_ACC:  acc_q  <= acc_q + {{(ACC_W-TERM_W){term_q[TERM_W-1]}}, term_q};
			default: ;
		endcase
	end

	// output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {(zero_q ? {VEL_W{1'b0}} : mean_q), forcing_q};
			m_tuser_q <= zero_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	a_accept_starts_divide: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (pc_q == PC_DIVI))
		else $error("accepted word did not start the divide");

	a_divide_length: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_DIV_STEP && cnt_q == '0) |=> (pc_q == PC_MEAN))
		else $error("divide loop did not end after its last step");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(pc_q) == PC_FINISH))
		else $error("result raised outside the finish step");

	a_term_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		term_idx_q != 2'd3)
		else $error("gain term index out of range");

	a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != PC_WAIT) |-> !s_tready)
		else $error("input taken while a word is in progress");

endmodule

FILE: tb/pid_forcing_adjust_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_forcing_adjust_tb
// Streams velocity samples into the PID forcing adjuster and checks every
// forcing update against a cycle-free prediction of the fixed-point maths.
// Gains and target are reprogrammed between drained phases, forcing in some of them.
// ----------------------------------------------------------------------------
module pid_forcing_adjust_tb;
	import pfa_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 130;

	typedef struct packed {
		logic [FORCE_W-1:0] forcing;
		logic [VEL_W-1:0]   mean;
		logic               vol_zero;
	} update_t;

	// Tracks the controller state and predicts each forcing update.
	class forcing_tracker;
		logic [VEL_W-1:0]   target;
		logic [GAIN_W-1:0]  kp, ki, kd;
		logic [63:0]        err_sum, prev_err, forcing;
		update_t            due_updates[$];
		int                 fails, checked, zero_words, rail_hits;

		function new();
			target = '0; kp = '0; ki = '0; kd = '0;
			err_sum = '0; prev_err = '0; forcing = '0;
			fails = 0; checked = 0; zero_words = 0; rail_hits = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_TARGET:  target = v[VEL_W-1:0];
				REG_KP:      kp = v[GAIN_W-1:0];
				REG_KI_TA:   ki = v[GAIN_W-1:0];
				REG_KD_TA:   kd = v[GAIN_W-1:0];
				REG_FORCING: begin
					forcing = v;
					err_sum = '0;
					prev_err = '0;
				end
				default: ;
			endcase
		endfunction

		function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63])
				return s[64] ? FORCE_MIN : FORCE_MAX;
			return s[63:0];
		endfunction

		// (gain * x) >> 24 on the magnitude, sign put back afterwards
		function logic [127:0] scaled(logic [GAIN_W-1:0] g, logic [63:0] x);
			logic [63:0]  m;
			logic [95:0]  p;
			logic [127:0] t;
			m = x[63] ? 64'd0 - x : x;
			p = {32'd0, m} * {64'd0, g};
			t = {56'd0, p[95:24]};
			return x[63] ? 128'd0 - t : t;
		endfunction

		function void take_sample(logic [VSUM_W-1:0] vs, logic [VOL_W-1:0] vol);
			logic [63:0]  mag, q, mv, e, diff;
			logic [127:0] acc;
			update_t      u;
			if (vol == '0) begin
				u.forcing = forcing;
				u.mean = '0;
				u.vol_zero = 1'b1;
				due_updates.push_back(u);
				zero_words++;
				return;
			end
			mag = vs[63] ? 64'd0 - vs : vs;
			q = mag / {32'd0, vol};
			if (vs[63])
				mv = (q > 64'h0000_8000_0000_0000) ? {{16{1'b1}}, VEL_MIN} : 64'd0 - q;
			else
				mv = (q > 64'h0000_7FFF_FFFF_FFFF) ? {16'd0, VEL_MAX} : q;
			e = {{16{target[VEL_W-1]}}, target} - mv;
			err_sum = sat_add(err_sum, e);
			diff = e - prev_err;
			acc = {{64{forcing[63]}}, forcing} + scaled(kp, e) + scaled(ki, err_sum)
				+ scaled(kd, diff);
			if (acc[127:63] == '0 || acc[127:63] == '1)
				forcing = acc[63:0];
			else
				forcing = acc[127] ? FORCE_MIN : FORCE_MAX;
			prev_err = e;
			u.forcing = forcing;
			u.mean = mv[VEL_W-1:0];
			u.vol_zero = 1'b0;
			due_updates.push_back(u);
		endfunction

		function void check_update(logic [FORCE_W-1:0] f, logic [VEL_W-1:0] m, logic z);
			update_t u;
			if (due_updates.size() == 0) begin
				$error("unexpected result word: forcing_out %h", f);
				fails++;
				return;
			end
			u = due_updates.pop_front();
			checked++;
			if (f == FORCE_MAX || f == FORCE_MIN)
				rail_hits++;
			if (f !== u.forcing) begin
				$error("forcing_out: expected %h, got %h", u.forcing, f);
				fails++;
			end
			if (m !== u.mean) begin
				$error("mean_velocity: expected %h, got %h", u.mean, m);
				fails++;
			end
			if (z !== u.vol_zero) begin
				$error("volume_zero: expected %b, got %b", u.vol_zero, z);
				fails++;
			end
		endfunction

		function int outstanding();
			return due_updates.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata   = '0;  // velocity_sum, cells_volume
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;         // forcing_out, mean_velocity
	logic [0:0]           m_tuser;         // volume_zero
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TARGET;
	logic [CFG_W-1:0]     cfg_data  = '0;

	bit             gaps_on = 1'b1;
	int             sent = 0;
	int             settings = 0;
	int             quiet = 0;
	forcing_tracker board = new();

	pid_forcing_adjust u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= (gaps_on && $urandom_range(0, 99) < 29) ? 1'b0 : 1'b1;
	end

	// Monitor: register writes, accepted samples and result words
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				board.set_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				board.take_sample(s_tdata[63:0], s_tdata[95:64]);
			if (m_tvalid && m_tready)
				board.check_update(m_tdata[63:0], m_tdata[111:64], m_tuser[0]);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet = 0;
		else
			quiet++;
		if (quiet == STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_vsum();
		logic [63:0] r;
		r = rand64();
		case ($urandom_range(0, 9))
			0, 1: return r;
			2: case ($urandom_range(0, 3))
				0: return FORCE_MAX;
				1: return FORCE_MIN;
				2: return 64'd0;
				default: return '1;
			endcase
			default: begin
				r = r >> $urandom_range(4, 62);
				return $urandom_range(0, 1) ? 64'd0 - r : r;
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_volume();
		case ($urandom_range(0, 19))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2, 3, 4, 5, 6, 7, 8, 9: return $urandom_range(1, 16);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [47:0] pick_target();
		logic [63:0] r;
		r = rand64() >> $urandom_range(16, 40);
		case ($urandom_range(0, 5))
			0: return VEL_MAX;
			1: return VEL_MIN;
			2: return 48'(rand64());
			default: return $urandom_range(0, 1) ? 48'd0 - r[47:0] : r[47:0];
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0200_0000);
		endcase
	endfunction

	function automatic logic [63:0] pick_forcing();
		logic [63:0] r;
		r = rand64() >> $urandom_range(8, 40);
		case ($urandom_range(0, 4))
			0: return FORCE_MAX;
			1: return FORCE_MIN;
			2: return rand64();
			default: return $urandom_range(0, 1) ? 64'd0 - r : r;
		endcase
	endfunction

	// Hold the word until the block takes it; valid is only dropped while idling.
	task automatic send_word(input logic [63:0] vs, input logic [31:0] vol);
		while (gaps_on && $urandom_range(0, 99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {vol, vs};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [47:0] tv, input logic [31:0] p, i, d,
			input bit load, input logic [63:0] f0);
		put_reg(REG_TARGET, {{16{tv[47]}}, tv});
		put_reg(REG_KP, {32'd0, p});
		put_reg(REG_KI_TA, {32'd0, i});
		put_reg(REG_KD_TA, {32'd0, d});
		if (load)
			put_reg(REG_FORCING, f0);
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains are zero: forcing must stay put
		send_word(64'd0, 32'd0);
		send_word(64'h0000_0001_0000_0000, 32'd1);
		drain();

		apply_settings(48'h0001_0000_0000, 32'h0100_0000, 32'h0020_0000, 32'h0008_0000,
			1'b1, 64'h0000_0001_0000_0000);
		send_word(FORCE_MAX, 32'd1);
		send_word(FORCE_MIN, 32'd1);
		send_word(64'h0000_8000_0000_0000, 32'd1);
		send_word(64'hFFFF_8000_0000_0000, 32'd1);
		send_word(FORCE_MIN, 32'hFFFF_FFFF);
		send_word(FORCE_MAX, 32'hFFFF_FFFF);
		send_word(64'd0 - 64'd7, 32'd2);
		send_word(64'd7, 32'd2);
		send_word('1, 32'd1);
		send_word(64'h1234_5678_9ABC_DEF0, 32'd0);
		send_word(64'h0000_0003_0000_0000, 32'd3);
		send_word(64'h0000_0006_0000_0000, 32'd3);
		drain();

		// drive the forcing into the upper rail, then the lower one
		apply_settings(VEL_MAX, '1, '1, '1, 1'b1, FORCE_MAX);
		send_word(FORCE_MIN, 32'd1);
		send_word(64'd0, 32'hFFFF_FFFF);
		drain();
		apply_settings(VEL_MIN, '1, '1, '1, 1'b1, FORCE_MIN);
		send_word(FORCE_MAX, 32'd1);
		send_word(FORCE_MAX, 32'd1);
		send_word(64'd0, 32'd0);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				apply_settings(VEL_MAX, '1, '1, '1, 1'b1, 64'd0);
			else if (ph == 1)
				apply_settings(VEL_MIN, '0, '0, '0, 1'b1, FORCE_MAX);
			else
				apply_settings(pick_target(), pick_gain(), pick_gain(), pick_gain(),
					ph == 2 || $urandom_range(0, 1) == 1, pick_forcing());
			// one long stretch at full rate on both sides
			gaps_on = (ph != 3);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (ph == 4 && n == PHASE_WORDS / 2)
					drain();
				send_word(pick_vsum(), pick_volume());
			end
			drain();
		end
		gaps_on = 1'b1;

		repeat (100) @(posedge clk);
		if (board.outstanding() != 0) begin
			$error("%0d expected results never arrived", board.outstanding());
			board.fails++;
		end
		$display("Sent %0d samples (%0d with zero volume) across %0d register settings.",
			sent, board.zero_words, settings);
		$display("Checked %0d forcing updates, %0d of them pinned at a rail.",
			board.checked, board.rail_hits);
		if (board.fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
